// ----- src/efbba_pkg.sv -----
// Package for the exact-fit bump block allocator.
// Holds the sequencer state type, table entry layout and command/status codes.
// No dependencies.
`default_nettype none

package efbba_pkg;

  localparam int DEF_MAX_BLOCKS   = 256;
  localparam int DEF_HEADER_BYTES = 32;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic CFG_HEAP_BASE   = 1'b0;
  localparam logic CFG_HEAP_LENGTH = 1'b1;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_FAIL = 2'd1;
  localparam logic [1:0] STATUS_NULL = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_NEW,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic [31:0] size;
    logic [31:0] addr;
    logic        in_use;
  } entry_t;

endpackage

`default_nettype wire

// ----- src/exact_fit_bump_block_allocator.sv -----
// An allocate scans for a free entry of the same size, else carves a new block; a free
// scans for the in-use entry at its address; a null free goes straight to the result.
// The scan reads one table entry per cycle. No new request is taken until the block is
// idle after the result word; a stalled result word holds it in the response state.
// Reset (synchronous) clears block count, bump offset and heap registers; the table is
// not cleared, only entries below the block count are ever read. Depends on efbba_pkg.
`default_nettype none

module exact_fit_bump_block_allocator #(
  parameter int MAX_BLOCKS   = efbba_pkg::DEF_MAX_BLOCKS,
  parameter int HEADER_BYTES = efbba_pkg::DEF_HEADER_BYTES
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        command,
  input  wire logic [31:0] alloc_size,
  input  wire logic [31:0] free_address,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      payload_address,
  output logic [1:0]       status,
  input  wire logic        cfg_write_enable,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int IDXW = $clog2(MAX_BLOCKS);
  localparam int CNTW = $clog2(MAX_BLOCKS + 1);

  efbba_pkg::state_t state, state_next;

  logic [31:0] heap_base;
  logic [31:0] heap_length;

  logic            req_cmd;
  logic [31:0]     req_size;
  logic [31:0]     req_addr;

  logic [CNTW-1:0] entry_count, entry_count_next;
  logic [31:0]     bytes_used, bytes_used_next;
  logic [CNTW-1:0] scan_idx, scan_idx_next;
  logic            check_valid, check_valid_next;
  logic [IDXW-1:0] check_idx, check_idx_next;
  logic [31:0]     res_addr, res_addr_next;
  logic [1:0]      res_status, res_status_next;

  efbba_pkg::entry_t mem [MAX_BLOCKS];
  efbba_pkg::entry_t mem_q;
  logic              mem_we;
  logic [IDXW-1:0]   mem_waddr;
  efbba_pkg::entry_t mem_wdata;

  logic        accept;
  logic        null_free;
  logic        issue;
  logic        hit;
  logic        scan_done;
  logic        table_full;
  logic        room;
  logic        out_free;
  logic [33:0] total;
  logic [31:0] new_addr;

  assign in_stall  = (state != efbba_pkg::ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign null_free = (command == efbba_pkg::CMD_FREE) && (free_address == 32'd0);
  assign out_free  = !out_valid || !out_stall;

  // The shared compare unit: one table entry checked per cycle.
  assign hit = check_valid &&
               ((req_cmd == efbba_pkg::CMD_ALLOC) ?
                  (!mem_q.in_use && (mem_q.size == req_size)) :
                  (mem_q.in_use && (mem_q.addr == req_addr)));
  assign issue      = (scan_idx < entry_count) && !hit;
  assign scan_done  = !hit && !issue && !check_valid;
  assign table_full = (entry_count == CNTW'(MAX_BLOCKS));
  assign total      = {2'b00, bytes_used} + 34'(HEADER_BYTES) + {2'b00, req_size};
  assign room       = (total < {2'b00, heap_length});
  assign new_addr   = heap_base + bytes_used + 32'(HEADER_BYTES);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      efbba_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = null_free ? efbba_pkg::ST_RESP : efbba_pkg::ST_SCAN;
        end
      end
      efbba_pkg::ST_SCAN: begin
        if (hit) begin
          state_next = efbba_pkg::ST_RESP;
        end else if (scan_done) begin
          state_next = (req_cmd == efbba_pkg::CMD_ALLOC) ? efbba_pkg::ST_NEW
                                                         : efbba_pkg::ST_RESP;
        end
      end
      efbba_pkg::ST_NEW: begin
        state_next = efbba_pkg::ST_RESP;
      end
      efbba_pkg::ST_RESP: begin
        if (out_free) begin
          state_next = efbba_pkg::ST_IDLE;
        end
      end
      default: state_next = efbba_pkg::ST_IDLE;
    endcase
  end

  // Datapath controls
  always_comb begin
    mem_we           = 1'b0;
    mem_waddr        = check_idx;
    mem_wdata        = mem_q;
    scan_idx_next    = scan_idx;
    check_valid_next = 1'b0;
    check_idx_next   = check_idx;
    res_addr_next    = res_addr;
    res_status_next  = res_status;
    entry_count_next = entry_count;
    bytes_used_next  = bytes_used;
    unique case (state)
      efbba_pkg::ST_IDLE: begin
        scan_idx_next   = '0;
        res_addr_next   = 32'd0;
        res_status_next = efbba_pkg::STATUS_NULL;
      end
      efbba_pkg::ST_SCAN: begin
        check_valid_next = issue;
        check_idx_next   = scan_idx[IDXW-1:0];
        if (issue) begin
          scan_idx_next = scan_idx + CNTW'(1);
        end
        if (hit) begin
          // Flip the in-use bit of the matching entry
          mem_we           = 1'b1;
          mem_wdata.in_use = ~mem_q.in_use;
          res_addr_next    = (req_cmd == efbba_pkg::CMD_ALLOC) ? mem_q.addr : 32'd0;
          res_status_next  = efbba_pkg::STATUS_OK;
        end else if (scan_done) begin
          res_addr_next   = 32'd0;
          res_status_next = efbba_pkg::STATUS_FAIL;
        end
      end
      efbba_pkg::ST_NEW: begin
        mem_waddr        = entry_count[IDXW-1:0];
        mem_wdata.size   = req_size;
        mem_wdata.addr   = new_addr;
        mem_wdata.in_use = 1'b1;
        if (!table_full && room) begin
          mem_we           = 1'b1;
          bytes_used_next  = total[31:0];
          entry_count_next = entry_count + CNTW'(1);
          res_addr_next    = new_addr;
          res_status_next  = efbba_pkg::STATUS_OK;
        end else begin
          res_addr_next   = 32'd0;
          res_status_next = efbba_pkg::STATUS_FAIL;
        end
      end
      efbba_pkg::ST_RESP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= efbba_pkg::ST_IDLE;
      heap_base   <= 32'd0;
      heap_length <= 32'd0;
      entry_count <= '0;
      bytes_used  <= 32'd0;
      scan_idx    <= '0;
      check_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      entry_count <= entry_count_next;
      bytes_used  <= bytes_used_next;
      scan_idx    <= scan_idx_next;
      check_valid <= check_valid_next;
      if (cfg_write_enable) begin
        if (cfg_index == efbba_pkg::CFG_HEAP_BASE) begin
          heap_base <= cfg_data;
        end else begin
          heap_length <= cfg_data;
        end
      end
      if (state == efbba_pkg::ST_RESP && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    check_idx  <= check_idx_next;
    res_addr   <= res_addr_next;
    res_status <= res_status_next;
    if (accept) begin
      req_cmd  <= command;
      req_size <= alloc_size;
      req_addr <= free_address;
    end
    if (state == efbba_pkg::ST_RESP && out_free) begin
      payload_address <= res_addr;
      status          <= res_status;
    end
  end

  // Block table
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_q <= mem[scan_idx[IDXW-1:0]];
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNTW'(MAX_BLOCKS))
    else $error("block count exceeds table depth");

  a_word_from_resp: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == efbba_pkg::ST_RESP)
    else $error("result word raised outside response state");

  a_write_when_busy: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == efbba_pkg::ST_SCAN || state == efbba_pkg::ST_NEW))
    else $error("table write outside scan or carve");

  a_null_free: assert property (@(posedge clk) disable iff (rst)
    accept && null_free |=> state == efbba_pkg::ST_RESP &&
                            res_status == efbba_pkg::STATUS_NULL)
    else $error("null free not short-circuited");

  a_carve_grows: assert property (@(posedge clk) disable iff (rst)
    state == efbba_pkg::ST_NEW && !table_full && room |=>
      entry_count == $past(entry_count) + CNTW'(1))
    else $error("carve did not add a block");

endmodule

`default_nettype wire
